>>> hw/rtl/atb_pkg.sv
package atb_pkg;

    // fixed field widths of the result beat and the register
    localparam int TH_W  = 25;
    localparam int IDX_W = 6;
    localparam int TOL_W = 25;

    // scaled store read address select
    localparam logic [1:0] RSEL_IDX = 2'd0;
    localparam logic [1:0] RSEL_J   = 2'd1;
    localparam logic [1:0] RSEL_K   = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       check_clr;
        logic       idx_clr;
        logic       idx_inc;
        logic       mul;
        logic       div_init;
        logic       div_step;
        logic       sc_wr;
        logic       latch_jk;
        logic [1:0] rsel;
        logic       cap_sj;
        logic       upd;
        logic       emit;
        logic       err_emit;
        logic       clear;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic err_cond;
        logic div_last;
        logic idx_last;
        logic has_under;
        logic has_over;
    } sts_t;

endpackage

>>> hw/rtl/atb_ram.sv
module atb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/atb_ctrl.sv
module atb_ctrl (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         last_weight,
    input  atb_pkg::sts_t sts,
    output atb_pkg::cmd_t cmd,
    output logic         busy
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_SC_RD  = 4'd2;
    localparam logic [3:0] S_SC_MUL = 4'd3;
    localparam logic [3:0] S_SC_INI = 4'd4;
    localparam logic [3:0] S_SC_DIV = 4'd5;
    localparam logic [3:0] S_SC_WR  = 4'd6;
    localparam logic [3:0] S_FIND   = 4'd7;
    localparam logic [3:0] S_RJ     = 4'd8;
    localparam logic [3:0] S_RK     = 4'd9;
    localparam logic [3:0] S_UPD    = 4'd10;
    localparam logic [3:0] S_EM_RD  = 4'd11;
    localparam logic [3:0] S_EM_OUT = 4'd12;
    localparam logic [3:0] S_ERR    = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign busy = (state_reg != S_IDLE);

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rsel   = atb_pkg::RSEL_IDX;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (last_weight)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (sts.err_cond)
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    cmd.idx_clr   = 1'b1;
                    cmd.check_clr = 1'b1;
                    state_next    = S_SC_RD;
                end
            end
            S_SC_RD:  state_next = S_SC_MUL;
            S_SC_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SC_INI;
            end
            S_SC_INI:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_SC_DIV;
            end
            S_SC_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_SC_WR;
                end
            end
            S_SC_WR:
            begin
                cmd.sc_wr = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = S_FIND;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SC_RD;
                end
            end
            S_FIND:
            begin
                if (!sts.has_under)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_EM_RD;
                end
                else if (!sts.has_over)
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    cmd.latch_jk = 1'b1;
                    state_next   = S_RJ;
                end
            end
            S_RJ:
            begin
                cmd.rsel   = atb_pkg::RSEL_J;
                state_next = S_RK;
            end
            S_RK:
            begin
                cmd.rsel   = atb_pkg::RSEL_K;
                cmd.cap_sj = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = S_FIND;
            end
            S_EM_RD:  state_next = S_EM_OUT;
            S_EM_OUT:
            begin
                cmd.emit = 1'b1;
                if (sts.idx_last)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_EM_RD;
                end
            end
            S_ERR:
            begin
                cmd.err_emit = 1'b1;
                cmd.clear    = 1'b1;
                state_next   = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/atb_datapath.sv
module atb_datapath #(
    parameter int MAX_ENTRIES   = 64,
    parameter int FRACTION_BITS = 24,
    parameter int WEIGHT_BITS   = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  atb_pkg::cmd_t              cmd,
    output atb_pkg::sts_t              sts,
    input  logic [WEIGHT_BITS-1:0]     weight_in,
    input  logic [atb_pkg::TOL_W-1:0]  tol,
    output logic                       result_valid,
    output logic [atb_pkg::IDX_W-1:0]  entry_index,
    output logic [atb_pkg::TH_W-1:0]   threshold,
    output logic [atb_pkg::IDX_W-1:0]  alias_index,
    output logic                       last_entry,
    output logic                       build_error
);

    localparam int IW   = $clog2(MAX_ENTRIES);
    localparam int CNTW = $clog2(MAX_ENTRIES + 2);
    localparam int NB   = $clog2(MAX_ENTRIES + 1);
    localparam int SUMW = WEIGHT_BITS + $clog2(MAX_ENTRIES);
    localparam int NUMW = WEIGHT_BITS + NB;
    localparam int SW   = NB + FRACTION_BITS;
    localparam int STW  = $clog2(SW);
    localparam int CW   = (SW > atb_pkg::TH_W) ? SW : atb_pkg::TH_W;
    localparam logic [SW-1:0] ONE = {{(NB - 1){1'b0}}, 1'b1, {FRACTION_BITS{1'b0}}};

    logic [CNTW-1:0]        count_reg;
    logic [SUMW-1:0]        sum_reg;
    logic [IW-1:0]          idx_reg;
    logic [NUMW-1:0]        prod_reg;
    logic [SUMW-1:0]        rem_reg;
    logic [SW-1:0]          dsh_reg;
    logic [SW-1:0]          quot_reg;
    logic [STW-1:0]         step_reg;
    logic [MAX_ENTRIES-1:0] under_reg;
    logic [MAX_ENTRIES-1:0] over_reg;
    logic [IW-1:0]          j_reg;
    logic [IW-1:0]          k_reg;
    logic [SW-1:0]          sj_reg;

    logic [WEIGHT_BITS-1:0] w_rdata;
    logic [SW-1:0]          sc_rdata;
    logic [IW-1:0]          al_rdata;
    logic [IW-1:0]          sc_raddr;
    logic                   sc_we;
    logic [IW-1:0]          sc_waddr;
    logic [SW-1:0]          sc_wdata;
    logic                   al_we;
    logic [IW-1:0]          al_waddr;
    logic [IW-1:0]          al_wdata;

    logic [NB-1:0]          n_val;
    logic                   w_we;
    logic [SUMW:0]          trial;
    logic [SUMW:0]          sum_ext;
    logic                   q_bit;
    logic [SUMW-1:0]        rem_next;
    logic [IW-1:0]          j_found;
    logic [IW-1:0]          k_found;
    logic [SW-1:0]          f_val;
    logic [SW-1:0]          delta;
    logic                   near_one;
    logic [CW-1:0]          th_wide;

    assign n_val = count_reg[NB-1:0];
    assign w_we  = cmd.load && (count_reg < CNTW'(MAX_ENTRIES));

    // status back to the controller
    assign sts.err_cond  = (count_reg > CNTW'(MAX_ENTRIES)) || (sum_reg == '0);
    assign sts.div_last  = (step_reg == STW'(SW - 1));
    assign sts.idx_last  = (CNTW'(idx_reg) == count_reg - CNTW'(1));
    assign sts.has_under = |under_reg;
    assign sts.has_over  = |over_reg;

    // lowest-index underfull and overfull entries
    always_comb
    begin
        j_found = '0;
        k_found = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (under_reg[i])
            begin
                j_found = IW'(i);
            end
            if (over_reg[i])
            begin
                k_found = IW'(i);
            end
        end
    end

    // one restoring division step
    assign sum_ext  = {1'b0, sum_reg};
    assign trial    = {rem_reg, dsh_reg[SW-1]};
    assign q_bit    = (trial >= sum_ext);
    assign rem_next = q_bit ? SUMW'(trial - sum_ext) : trial[SUMW-1:0];

    // pairing round arithmetic
    assign f_val    = sc_rdata + sj_reg - ONE;
    assign delta    = (f_val >= ONE) ? (f_val - ONE) : (ONE - f_val);
    assign near_one = CW'(delta) < CW'(tol);

    // store port selection
    always_comb
    begin
        case (cmd.rsel)
            atb_pkg::RSEL_J: sc_raddr = j_reg;
            atb_pkg::RSEL_K: sc_raddr = k_reg;
            default:         sc_raddr = idx_reg;
        endcase
        sc_we    = cmd.sc_wr || cmd.upd;
        sc_waddr = cmd.upd ? k_reg : idx_reg;
        sc_wdata = cmd.upd ? (near_one ? ONE : f_val) : quot_reg;
        al_we    = cmd.sc_wr || cmd.upd;
        al_waddr = cmd.upd ? j_reg : idx_reg;
        al_wdata = cmd.upd ? k_reg : idx_reg;
    end

    atb_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_ENTRIES)) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (count_reg[IW-1:0]),
        .wdata (weight_in),
        .raddr (idx_reg),
        .rdata (w_rdata)
    );

    atb_ram #(.WIDTH(SW), .DEPTH(MAX_ENTRIES)) u_scaled_ram (
        .clk   (clk),
        .we    (sc_we),
        .waddr (sc_waddr),
        .wdata (sc_wdata),
        .raddr (sc_raddr),
        .rdata (sc_rdata)
    );

    atb_ram #(.WIDTH(IW), .DEPTH(MAX_ENTRIES)) u_alias_ram (
        .clk   (clk),
        .we    (al_we),
        .waddr (al_waddr),
        .wdata (al_wdata),
        .raddr (idx_reg),
        .rdata (al_rdata)
    );

    // entry count, running sum and class bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            under_reg <= '0;
            over_reg  <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
            end
            else if (cmd.load)
            begin
                if (w_we)
                begin
                    count_reg <= count_reg + CNTW'(1);
                    sum_reg   <= sum_reg + SUMW'(weight_in);
                end
                else
                begin
                    count_reg <= CNTW'(MAX_ENTRIES + 1);
                end
            end
            if (cmd.check_clr)
            begin
                under_reg <= '0;
                over_reg  <= '0;
            end
            if (cmd.sc_wr)
            begin
                under_reg[idx_reg] <= (quot_reg < ONE);
                over_reg[idx_reg]  <= (quot_reg > ONE);
            end
            if (cmd.upd)
            begin
                under_reg[j_reg] <= 1'b0;
                if (near_one)
                begin
                    over_reg[k_reg] <= 1'b0;
                end
                else if (f_val < ONE)
                begin
                    over_reg[k_reg]  <= 1'b0;
                    under_reg[k_reg] <= 1'b1;
                end
            end
        end
    end

    // index counter, scaling datapath (multiply, then shift-subtract divide) and pairing latches
    always_ff @(posedge clk)
    begin
        if (cmd.idx_clr)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + IW'(1);
        end
        if (cmd.mul)
        begin
            prod_reg <= NUMW'(n_val) * NUMW'(w_rdata);
        end
        if (cmd.div_init)
        begin
            rem_reg  <= SUMW'(prod_reg[NUMW-1:NB]);
            dsh_reg  <= {prod_reg[NB-1:0], {FRACTION_BITS{1'b0}}};
            quot_reg <= '0;
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_next;
            dsh_reg  <= {dsh_reg[SW-2:0], 1'b0};
            quot_reg <= {quot_reg[SW-2:0], q_bit};
            step_reg <= step_reg + STW'(1);
        end
        if (cmd.latch_jk)
        begin
            j_reg <= j_found;
            k_reg <= k_found;
        end
        if (cmd.cap_sj)
        begin
            sj_reg <= sc_rdata;
        end
    end

    // result beat register
    assign th_wide = CW'(over_reg[idx_reg] ? ONE : sc_rdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= cmd.emit || cmd.err_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            entry_index <= atb_pkg::IDX_W'(idx_reg);
            threshold   <= th_wide[atb_pkg::TH_W-1:0];
            alias_index <= atb_pkg::IDX_W'(al_rdata);
            last_entry  <= sts.idx_last;
            build_error <= 1'b0;
        end
        else if (cmd.err_emit)
        begin
            entry_index <= '0;
            threshold   <= '0;
            alias_index <= '0;
            last_entry  <= 1'b1;
            build_error <= 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_pair_classes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd |-> (under_reg[j_reg] && over_reg[k_reg]))
        else $error("round pairs entries of the wrong class");

    a_donor_overfull: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd |-> (sc_rdata >= ONE))
        else $error("donor entry below one");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && build_error) |-> last_entry)
        else $error("error beat without last mark");

    a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (count_reg == '0) && (sum_reg == '0))
        else $error("build state not cleared");
`endif

endmodule

>>> hw/rtl/alias_table_builder.sv
// walker alias table builder
// input: pulse start with weight and last_weight while busy is low; one
// weight is taken per cycle. weights beyond MAX_ENTRIES are dropped and
// turn the build into an error.
// a beat with last_weight set starts the build and raises busy until the
// whole table, or the error beat, has been sent.
// register: tolerance_we writes tolerance_wdata at once; write it only
// while busy is low.
// output: one beat per entry on result_valid, in entry order, with
// last_entry on the final one; on a zero sum, too many weights or an
// underfull entry with nothing left to pair, a single beat with
// build_error and last_entry instead.
// build for n entries: each entry is scaled in turn by a single shared
// shift-subtract divider; each pairing round makes two reads of the
// scaled store, at most n rounds; the emit pass reads the stores once
// per entry before its beat.
// reset clears the weight count, sum and class bits, tolerance goes to one LSB.
// results cannot be held off: each beat is present for one cycle only.
module alias_table_builder #(
    parameter int MAX_ENTRIES   = 64,
    parameter int FRACTION_BITS = 24,
    parameter int WEIGHT_BITS   = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [31:0]               weight,
    input  logic                      last_weight,
    input  logic                      tolerance_we,
    input  logic [atb_pkg::TOL_W-1:0] tolerance_wdata,
    output logic                      result_valid,
    output logic [atb_pkg::IDX_W-1:0] entry_index,
    output logic [atb_pkg::TH_W-1:0]  threshold,
    output logic [atb_pkg::IDX_W-1:0] alias_index,
    output logic                      last_entry,
    output logic                      build_error
);

    atb_pkg::cmd_t cmd;
    atb_pkg::sts_t sts;

    logic [atb_pkg::TOL_W-1:0] tol_reg;

    // tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= atb_pkg::TOL_W'(1);
        end
        else if (tolerance_we)
        begin
            tol_reg <= tolerance_wdata;
        end
    end

    atb_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .last_weight (last_weight),
        .sts         (sts),
        .cmd         (cmd),
        .busy        (busy)
    );

    atb_datapath #(
        .MAX_ENTRIES   (MAX_ENTRIES),
        .FRACTION_BITS (FRACTION_BITS),
        .WEIGHT_BITS   (WEIGHT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .weight_in    (weight[WEIGHT_BITS-1:0]),
        .tol          (tol_reg),
        .result_valid (result_valid),
        .entry_index  (entry_index),
        .threshold    (threshold),
        .alias_index  (alias_index),
        .last_entry   (last_entry),
        .build_error  (build_error)
    );

endmodule
